// File: rtl/core/gtm_pkg.sv
// Shared types, register codes and helpers for the growth trend monitor.
`timescale 1ns / 1ps

package gtm_pkg;

  localparam int KEY_W    = 22;
  localparam int SAMPLE_W = 31;
  localparam int COUNT_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_UNIQUE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_RUN_NEEDED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_ALARM_LIMIT = 2'd2;

  localparam logic [COUNT_W-1:0] RISE_RUN_RESET = 16'd3;
  localparam logic [COUNT_W-1:0] PEAK_LIMIT_RESET = 16'd3;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [SAMPLE_W-1:0] last_value;
    logic [SAMPLE_W-1:0] peak_value;
    logic [COUNT_W-1:0]  rise_run;
    logic [COUNT_W-1:0]  peak_tally;
    logic                exempt_mark;
  } entry_t;

  typedef struct packed {
    logic               watch_unique;
    logic [COUNT_W-1:0] rise_run_needed;
    logic [COUNT_W-1:0] peak_alarm_limit;
  } cfg_t;

  typedef struct packed {
    logic leak_alarm;
    logic table_full;
    logic created;
  } result_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
  endfunction

endpackage

// File: rtl/core/gtm_table.sv
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module gtm_table import gtm_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int IDX_W   = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/gtm_ctrl.sv
// Sequencer: key scan over the entry memory, entry update or creation, result hand-off.
`timescale 1ns / 1ps

module gtm_ctrl import gtm_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int IDX_W   = 6,
  parameter int CNT_W   = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KEY_W-1:0]    proc_id,
  input  logic [SAMPLE_W-1:0] proportional_size,
  input  logic [SAMPLE_W-1:0] unique_size,
  input  logic                exempt,
  output logic                res_valid,
  output result_t             res,
  input  logic                res_take,
  output logic                mem_we,
  output logic [IDX_W-1:0]    mem_waddr,
  output entry_t              mem_wdata,
  output logic [IDX_W-1:0]    mem_raddr,
  input  entry_t              mem_rdata
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_UPDATE = 5'b00100,
    S_CREATE = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]    fill;       // entries are never freed: valid == index < fill
  logic [IDX_W-1:0]    ptr;
  logic [IDX_W-1:0]    hit_idx;
  logic [KEY_W-1:0]    item_key;
  logic [SAMPLE_W-1:0] item_n;
  logic                item_ex;
  entry_t              ent;
  result_t             res_reg;

  logic                accept;
  logic                key_hit;
  logic                scan_last;
  logic [COUNT_W-1:0]  run_a;
  logic                new_peak;
  logic                bump;
  entry_t              upd;
  entry_t              fresh;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign key_hit   = (mem_rdata.key == item_key);
  assign scan_last = ((CNT_W'(ptr) + CNT_W'(1)) == fill);

  // read pipeline: entry ptr is on rdata while ptr+1 is being fetched
  assign mem_raddr = (state == S_SCAN) ? ptr + IDX_W'(1) : '0;

  always_comb begin
    new_peak = (ent.peak_value < item_n);
    if (ent.last_value < item_n) begin
      run_a = sat_inc(ent.rise_run);
    end else if (ent.last_value > item_n) begin
      run_a = '0;
    end else begin
      run_a = ent.rise_run;
    end
    bump = (run_a >= cfg.rise_run_needed) && new_peak;
    upd             = ent;
    upd.last_value  = item_n;
    upd.rise_run    = bump ? '0 : run_a;
    upd.peak_tally  = bump ? sat_inc(ent.peak_tally) : ent.peak_tally;
    upd.peak_value  = new_peak ? item_n : ent.peak_value;
  end

  always_comb begin
    fresh.key         = item_key;
    fresh.last_value  = item_n;
    fresh.peak_value  = item_n;
    fresh.rise_run    = COUNT_W'(1);
    fresh.peak_tally  = '0;
    fresh.exempt_mark = item_ex;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = hit_idx;
    mem_wdata = upd;
    if (state == S_UPDATE) begin
      mem_we = 1'b1;
    end else if (state == S_CREATE && fill != CNT_W'(ENTRIES)) begin
      mem_we    = 1'b1;
      mem_waddr = fill[IDX_W-1:0];
      mem_wdata = fresh;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (fill == '0) ? S_CREATE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (key_hit) begin
          state_next = S_UPDATE;
        end else if (scan_last) begin
          state_next = S_CREATE;
        end
      end
      S_UPDATE: state_next = S_FINISH;
      S_CREATE: state_next = S_FINISH;
      S_FINISH: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (mem_we && state == S_CREATE) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_key <= proc_id;
      item_n   <= cfg.watch_unique ? unique_size : proportional_size;
      item_ex  <= exempt;
      ptr      <= '0;
    end
    if (state == S_SCAN) begin
      if (key_hit) begin
        ent     <= mem_rdata;
        hit_idx <= ptr;
      end else begin
        ptr <= ptr + IDX_W'(1);
      end
    end
    if (state == S_UPDATE) begin
      res_reg.leak_alarm <= !ent.exempt_mark && (upd.peak_tally >= cfg.peak_alarm_limit);
      res_reg.table_full <= 1'b0;
      res_reg.created    <= 1'b0;
    end
    if (state == S_CREATE) begin
      if (fill == CNT_W'(ENTRIES)) begin
        res_reg.leak_alarm <= 1'b0;
        res_reg.table_full <= 1'b1;
        res_reg.created    <= 1'b0;
      end else begin
        // fresh entry has a zero tally
        res_reg.leak_alarm <= !item_ex && (cfg.peak_alarm_limit == '0);
        res_reg.table_full <= 1'b0;
        res_reg.created    <= 1'b1;
      end
    end
  end

  assign res_valid = (state == S_FINISH);
  assign res       = res_reg;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(ENTRIES))
    else $error("fill count beyond table size");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CNT_W'(ptr) < fill))
    else $error("scan pointer past filled entries");

  a_create_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_CREATE && fill != CNT_W'(ENTRIES)) |=> (fill == $past(fill) + CNT_W'(1)))
    else $error("created entry did not advance fill count");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.table_full) |-> (fill == CNT_W'(ENTRIES) && !res.created && !res.leak_alarm))
    else $error("table_full result with free entries");

endmodule

// File: rtl/core/per_key_growth_trend_monitor_unit.sv
// Top level: configuration registers, output register, sequencer and entry memory.
// Flow: after accept the sequencer scans the entries in use in order until the key matches,
//   then updates that entry, or creates one for a new key or reports a full table.
// Requests: one at a time; the next is accepted the cycle after the result is
//   registered in the output register, so output stalls hold off the next request.
// Reset clears the configuration to defaults and the fill count; no memory clearing pass.
`timescale 1ns / 1ps

module per_key_growth_trend_monitor_unit import gtm_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KEY_W-1:0]     proc_id,
  input  logic [SAMPLE_W-1:0]  proportional_size,
  input  logic [SAMPLE_W-1:0]  unique_size,
  input  logic                 exempt,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 leak_alarm,
  output logic                 table_full,
  output logic                 created
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  cfg_t             cfg;
  logic             res_valid;
  result_t          res;
  logic             res_take;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.watch_unique     <= 1'b0;
      cfg.rise_run_needed  <= RISE_RUN_RESET;
      cfg.peak_alarm_limit <= PEAK_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WATCH_UNIQUE:     cfg.watch_unique     <= cfg_data[0];
        CFG_RISE_RUN_NEEDED:  cfg.rise_run_needed  <= cfg_data;
        CFG_PEAK_ALARM_LIMIT: cfg.peak_alarm_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register frees up in the same cycle it is taken
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      leak_alarm <= res.leak_alarm;
      table_full <= res.table_full;
      created    <= res.created;
    end
  end

  gtm_ctrl #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .proc_id           (proc_id),
    .proportional_size (proportional_size),
    .unique_size       (unique_size),
    .exempt            (exempt),
    .res_valid         (res_valid),
    .res               (res),
    .res_take          (res_take),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata)
  );

  gtm_table #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
